// ===== rtl/blepn_pkg.sv =====
// Package for the BLE advertising name parser.
// Holds the result record, result kinds, configuration record, register
// indexes, reset values and the channel index mapping. No dependencies.
package blepn_pkg;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_NAME     = 3'd1,
    KIND_OVERRUN  = 3'd2,
    KIND_ZERO_LEN = 3'd3,
    KIND_END      = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         name_char;
    logic [31:0]        access_addr;
    logic               is_data_pdu;
    logic [3:0]         pdu_type;
    logic               tx_addr_random;
    logic               rx_addr_random;
    logic [5:0]         payload_length;
    logic [5:0]         chan_index;
    logic signed [8:0]  rssi_value;
    logic               last;
  } res_t;

  typedef struct packed {
    logic signed [7:0] rssi_offset;
    logic [7:0]        name_type_code;
    logic [3:0]        parsed_adv_type;
  } cfg_t;

  localparam logic [1:0] CFG_RSSI_OFFSET     = 2'd0;
  localparam logic [1:0] CFG_NAME_TYPE_CODE  = 2'd1;
  localparam logic [1:0] CFG_PARSED_ADV_TYPE = 2'd2;

  localparam logic signed [7:0] RSSI_OFFSET_RST     = -8'sd54;
  localparam logic [7:0]        NAME_TYPE_CODE_RST  = 8'h09;
  localparam logic [3:0]        PARSED_ADV_TYPE_RST = 4'h0;

  // First link layer channel index that belongs to an advertising channel.
  localparam logic [5:0] FIRST_ADV_CHAN = 6'd37;

  // Depth of the result queue; it must hold at least the two results
  // that a single byte can cause.
  localparam int unsigned RES_DEPTH = 4;

  // Maps MHz above 2402 onto the link layer channel index. The three
  // advertising channels sit at 2402, 2426 and 2480 MHz.
  function automatic logic [5:0] chan_from_offset(input logic [6:0] off);
    logic [6:0] lo;
    logic [6:0] hi;
    logic [5:0] chan;
    lo = off - 7'd2;
    hi = off - 7'd26;
    if (off == 7'd0) begin
      chan = 6'd37;
    end else if (off < 7'd24) begin
      chan = (off < 7'd2) ? 6'd0 : lo[6:1];
    end else if (off == 7'd24) begin
      chan = 6'd38;
    end else if (off < 7'd78) begin
      chan = (off < 7'd26) ? 6'd11 : hi[6:1] + 6'd11;
    end else begin
      chan = 6'd39;
    end
    return chan;
  endfunction

endpackage

// ===== rtl/blepn_parser.sv =====
// Per-byte packet parser: holds the per-packet state and works out, for
// each accepted byte, the next state and up to two result records.
// Depends on blepn_pkg.
module blepn_parser #(
  parameter int unsigned MAX_PACKET_BYTES = 64,
  parameter int unsigned AD_START_BYTE    = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [7:0]         data_byte_i,
  input  logic               packet_end_i,
  input  logic [6:0]         channel_offset_i,
  input  logic signed [7:0]  rssi_raw_i,
  input  blepn_pkg::cfg_t    cfg_i,
  output blepn_pkg::res_t    res_a_o,
  output blepn_pkg::res_t    res_b_o,
  output logic [1:0]         res_cnt_o
);
  import blepn_pkg::*;

  localparam int unsigned IDX_TOP = (MAX_PACKET_BYTES > AD_START_BYTE) ?
                                    MAX_PACKET_BYTES : AD_START_BYTE;
  localparam int unsigned BW      = $clog2(IDX_TOP + 1);
  localparam int unsigned PW      = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned CW      = ((PW > 8) ? PW : 8) + 2;
  localparam int unsigned ROOM    = (AD_START_BYTE < MAX_PACKET_BYTES) ?
                                    (MAX_PACKET_BYTES - AD_START_BYTE) : 0;

  localparam logic [BW-1:0] IDX_MAX   = BW'(MAX_PACKET_BYTES);
  localparam logic [BW-1:0] IDX_HDR0  = BW'(4);
  localparam logic [BW-1:0] IDX_HDR1  = BW'(5);
  localparam logic [BW-1:0] IDX_AD    = BW'(AD_START_BYTE);
  localparam logic [CW-1:0] ROOM_C    = CW'(ROOM);

  typedef enum logic [1:0] {
    PH_LEN   = 2'd0,
    PH_TYPE  = 2'd1,
    PH_VALUE = 2'd2
  } phase_e;

  logic [BW-1:0] byte_idx_q,  byte_idx_d;
  logic [31:0]   addr_q,      addr_d;
  logic [3:0]    hdr_type_q,  hdr_type_d;
  logic [1:0]    hdr_flags_q, hdr_flags_d;
  logic [5:0]    pdu_len_q,   pdu_len_d;
  logic [PW-1:0] ad_pos_q,    ad_pos_d;
  logic [7:0]    struct_left_q, struct_left_d;
  phase_e        phase_q,     phase_d;
  logic          name_act_q,  name_act_d;
  logic          stopped_q,   stopped_d;

  logic [5:0]    len_ad;
  logic [CW-1:0] lim;
  logic [CW-1:0] pos_ext;
  logic [5:0]    chan_now;
  logic          is_data;
  logic [5:0]    len_now;
  logic [7:0]    left_dec;
  res_t          main_res;
  res_t          end_res;
  logic          main_vld;

  assign len_ad   = (pdu_len_q > 6'd6) ? (pdu_len_q - 6'd6) : 6'd0;
  assign lim      = (CW'(len_ad) < ROOM_C) ? CW'(len_ad) : ROOM_C;
  assign pos_ext  = CW'(ad_pos_q);
  assign chan_now = chan_from_offset(channel_offset_i);
  assign is_data  = chan_now < FIRST_ADV_CHAN;
  assign len_now  = is_data ? {1'b0, data_byte_i[4:0]} : data_byte_i[5:0];
  assign left_dec = struct_left_q - 8'd1;

  always_comb begin
    byte_idx_d    = byte_idx_q;
    addr_d        = addr_q;
    hdr_type_d    = hdr_type_q;
    hdr_flags_d   = hdr_flags_q;
    pdu_len_d     = pdu_len_q;
    ad_pos_d      = ad_pos_q;
    struct_left_d = struct_left_q;
    phase_d       = phase_q;
    name_act_d    = name_act_q;
    stopped_d     = stopped_q;
    main_res      = '0;
    main_vld      = 1'b0;

    if (byte_idx_q < IDX_MAX) begin
      if (byte_idx_q < IDX_HDR0) begin
        addr_d = addr_q | ({24'b0, data_byte_i} << {byte_idx_q[1:0], 3'b000});
      end else if (byte_idx_q == IDX_HDR0) begin
        hdr_type_d  = data_byte_i[3:0];
        hdr_flags_d = data_byte_i[7:6];
      end else if (byte_idx_q == IDX_HDR1) begin
        pdu_len_d = len_now;
        stopped_d = is_data || (hdr_type_q != cfg_i.parsed_adv_type) ||
                    (len_now <= 6'd6);
        main_vld                = 1'b1;
        main_res.kind           = KIND_HEADER;
        main_res.access_addr    = addr_q;
        main_res.is_data_pdu    = is_data;
        main_res.payload_length = len_now;
        main_res.chan_index     = chan_now;
        if (!is_data) begin
          main_res.pdu_type       = hdr_type_q;
          main_res.tx_addr_random = hdr_flags_q[0];
          main_res.rx_addr_random = hdr_flags_q[1];
        end
      end else if (byte_idx_q >= IDX_AD && !stopped_q && pos_ext < lim) begin
        case (phase_q)
          PH_LEN: begin
            if (pos_ext + CW'(1) + CW'(data_byte_i) > lim) begin
              main_vld      = 1'b1;
              main_res.kind = KIND_OVERRUN;
              stopped_d     = 1'b1;
            end else if (data_byte_i == 8'd0) begin
              main_vld      = 1'b1;
              main_res.kind = KIND_ZERO_LEN;
              stopped_d     = 1'b1;
            end else begin
              struct_left_d = data_byte_i;
              phase_d       = PH_TYPE;
            end
          end
          PH_TYPE: begin
            name_act_d    = (data_byte_i == cfg_i.name_type_code);
            struct_left_d = left_dec;
            phase_d       = (left_dec == 8'd0) ? PH_LEN : PH_VALUE;
          end
          default: begin
            if (name_act_q) begin
              main_vld      = 1'b1;
              main_res.kind = KIND_NAME;
              main_res.name_char = (data_byte_i inside {[8'h20:8'h7E]}) ?
                                   data_byte_i : 8'h2E;
            end
            struct_left_d = left_dec;
            if (left_dec == 8'd0) begin
              phase_d = PH_LEN;
            end
          end
        endcase
        ad_pos_d = ad_pos_q + PW'(1);
      end
      byte_idx_d = byte_idx_q + BW'(1);
    end

    // The end of a packet returns every per-packet register to reset.
    if (packet_end_i) begin
      byte_idx_d    = '0;
      addr_d        = '0;
      hdr_type_d    = '0;
      hdr_flags_d   = '0;
      pdu_len_d     = '0;
      ad_pos_d      = '0;
      struct_left_d = '0;
      phase_d       = PH_LEN;
      name_act_d    = 1'b0;
      stopped_d     = 1'b0;
    end
  end

  always_comb begin
    end_res            = '0;
    end_res.kind       = KIND_END;
    end_res.rssi_value = 9'(rssi_raw_i) + 9'(cfg_i.rssi_offset);
    end_res.last       = 1'b1;
  end

  always_comb begin
    res_b_o = end_res;
    if (main_vld) begin
      res_a_o      = main_res;
      res_a_o.last = !packet_end_i;
    end else begin
      res_a_o = end_res;
    end
    res_cnt_o = {1'b0, main_vld} + {1'b0, packet_end_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q    <= '0;
      addr_q        <= '0;
      hdr_type_q    <= '0;
      hdr_flags_q   <= '0;
      pdu_len_q     <= '0;
      ad_pos_q      <= '0;
      struct_left_q <= '0;
      phase_q       <= PH_LEN;
      name_act_q    <= 1'b0;
      stopped_q     <= 1'b0;
    end else if (fire_i) begin
      byte_idx_q    <= byte_idx_d;
      addr_q        <= addr_d;
      hdr_type_q    <= hdr_type_d;
      hdr_flags_q   <= hdr_flags_d;
      pdu_len_q     <= pdu_len_d;
      ad_pos_q      <= ad_pos_d;
      struct_left_q <= struct_left_d;
      phase_q       <= phase_d;
      name_act_q    <= name_act_d;
      stopped_q     <= stopped_d;
    end
  end

endmodule

// ===== rtl/blepn_res_fifo.sv =====
// Result queue: takes up to two result records per cycle and hands them
// out one per transaction in order. Depends on blepn_pkg.
module blepn_res_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_cnt_i,
  input  blepn_pkg::res_t  push_a_i,
  input  blepn_pkg::res_t  push_b_i,
  input  logic             pop_i,
  output blepn_pkg::res_t  head_o,
  output logic             not_empty_o,
  output logic             room_two_o
);
  import blepn_pkg::*;

  localparam int unsigned AW = $clog2(RES_DEPTH);
  localparam int unsigned CNTW = $clog2(RES_DEPTH + 1);

  res_t            mem_q [RES_DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] cnt_q;
  logic [AW-1:0]   wr_ptr_nx;
  logic            do_pop;

  assign wr_ptr_nx   = wr_ptr_q + AW'(1);
  assign not_empty_o = cnt_q != '0;
  assign room_two_o  = cnt_q <= CNTW'(RES_DEPTH - 2);
  assign head_o      = mem_q[rd_ptr_q];
  assign do_pop      = pop_i && not_empty_o;

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_a_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + AW'(push_cnt_i);
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      cnt_q <= cnt_q + CNTW'(push_cnt_i) - CNTW'(do_pop);
    end
  end

endmodule

// ===== rtl/ble_adv_pdu_name_parser_core.sv =====
// Top level of the BLE advertising name parser: configuration registers,
// per-byte parser and result queue. Depends on blepn_pkg, blepn_parser
// and blepn_res_fifo.
//
// The block takes one packet byte per cycle, access address first, and
// updates its parser state in the cycle the byte is accepted. A byte causes
// at most two results (a header, name character or walk status, followed
// by the end-of-packet result on the final byte); they enter a four-entry
// result queue and leave it in order, one per output transaction. Input
// ready is high whenever the queue has room for two results, so the input
// rate is one byte per cycle as long as the output side takes one result
// per cycle and bytes average at most one result each. Configuration
// writes take effect at the next clock edge.
module ble_adv_pdu_name_parser_core #(
  parameter int unsigned MAX_PACKET_BYTES = 64,
  parameter int unsigned AD_START_BYTE    = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              packet_end_i,
  input  logic [6:0]        channel_offset_i,
  input  logic signed [7:0] rssi_raw_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [7:0]        cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        kind_o,
  output logic [7:0]        name_char_o,
  output logic [31:0]       access_addr_o,
  output logic              is_data_pdu_o,
  output logic [3:0]        pdu_type_o,
  output logic              tx_addr_random_o,
  output logic              rx_addr_random_o,
  output logic [5:0]        payload_length_o,
  output logic [5:0]        chan_index_o,
  output logic signed [8:0] rssi_value_o,
  output logic              last_o
);
  import blepn_pkg::*;

  cfg_t       cfg_q;
  logic       in_fire;
  logic       room_two;
  res_t       res_a;
  res_t       res_b;
  logic [1:0] res_cnt;
  logic [1:0] push_cnt;
  res_t       head;

  assign in_ready_o = room_two;
  assign in_fire    = in_valid_i && room_two;
  assign push_cnt   = in_fire ? res_cnt : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rssi_offset     <= RSSI_OFFSET_RST;
      cfg_q.name_type_code  <= NAME_TYPE_CODE_RST;
      cfg_q.parsed_adv_type <= PARSED_ADV_TYPE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RSSI_OFFSET:     cfg_q.rssi_offset     <= cfg_data_i;
        CFG_NAME_TYPE_CODE:  cfg_q.name_type_code  <= cfg_data_i;
        CFG_PARSED_ADV_TYPE: cfg_q.parsed_adv_type <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  blepn_parser #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
    .AD_START_BYTE    (AD_START_BYTE)
  ) u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (in_fire),
    .data_byte_i      (data_byte_i),
    .packet_end_i     (packet_end_i),
    .channel_offset_i (channel_offset_i),
    .rssi_raw_i       (rssi_raw_i),
    .cfg_i            (cfg_q),
    .res_a_o          (res_a),
    .res_b_o          (res_b),
    .res_cnt_o        (res_cnt)
  );

  blepn_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push_a_i    (res_a),
    .push_b_i    (res_b),
    .pop_i       (out_ready_i),
    .head_o      (head),
    .not_empty_o (out_valid_o),
    .room_two_o  (room_two)
  );

  assign kind_o           = head.kind;
  assign name_char_o      = head.name_char;
  assign access_addr_o    = head.access_addr;
  assign is_data_pdu_o    = head.is_data_pdu;
  assign pdu_type_o       = head.pdu_type;
  assign tx_addr_random_o = head.tx_addr_random;
  assign rx_addr_random_o = head.rx_addr_random;
  assign payload_length_o = head.payload_length;
  assign chan_index_o     = head.chan_index;
  assign rssi_value_o     = head.rssi_value;
  assign last_o           = head.last;

endmodule
